// ===== hdl/hsv_skin_pixel_classifier_assert.svh =====
// Assertion macros for the HSV skin pixel classifier.
// No dependencies; included by the RTL files that carry assertions.
`ifndef HSV_SKIN_PIXEL_CLASSIFIER_ASSERT_SVH
`define HSV_SKIN_PIXEL_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define HSVSKIN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSVSKIN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HSVSKIN_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define HSVSKIN_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/hsvskin_pkg.sv =====
// Shared types and constants for the HSV skin pixel classifier.
// No dependencies.
`default_nettype none

package hsvskin_pkg;

   // Channel and configuration port widths.
   localparam int PIXEL_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 9;

   // Register field widths.
   localparam int HUE_WIDTH = 9;
   localparam int SAT_WIDTH = 7;
   localparam int VALUE_WIDTH = 8;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;

   // Register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_HUE_LOWER = 8'd0,
      REG_HUE_WRAP = 8'd1,
      REG_SAT_MIN = 8'd2,
      REG_VALUE_MIN = 8'd3
   } csr_reg_type;

   // Register reset values.
   localparam logic [HUE_WIDTH-1:0] HUE_LOWER_RESET = 9'd45;
   localparam logic [HUE_WIDTH-1:0] HUE_WRAP_RESET = 9'd330;
   localparam logic [SAT_WIDTH-1:0] SAT_MIN_RESET = 7'd15;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN_RESET = 8'd25;

   // Hue and saturation arithmetic constants; angles in degrees.
   localparam int HD_WIDTH = 19;
   localparam logic signed [HD_WIDTH-1:0] DEG_SECTOR = 19'sd60;
   localparam logic signed [HD_WIDTH-1:0] DEG_GREEN_BASE = 19'sd120;
   localparam logic signed [HD_WIDTH-1:0] DEG_BLUE_BASE = 19'sd240;
   localparam logic signed [HD_WIDTH-1:0] DEG_FULL_TURN = 19'sd360;
   localparam int PROD_WIDTH = 17;
   localparam int SAT_PROD_WIDTH = 15;
   localparam logic [SAT_PROD_WIDTH-1:0] PERCENT_FULL = 15'd100;

endpackage

`default_nettype wire

// ===== hdl/hsv_skin_pixel_classifier.sv =====
// HSV skin pixel classifier: one RGB pixel in, one skin flag out.
// Depends on hsvskin_pkg and hsv_skin_pixel_classifier_assert.svh.
//
// Usage:
//   The req channel takes one pixel per transaction (req_red, req_green,
//   req_blue). The rsp channel returns one skin flag per pixel, in order.
//   The csr channel writes the four limit registers by index; csr_ready is
//   always high and writes to unknown indexes are dropped. Write limits only
//   while no pixel is in flight.
//   A req transaction loads the pixel into the input register, and the
//   classified flag then moves into the result register once that is
//   free. Throughput is one pixel per cycle while the receiver does not
//   stall, set by the single classify stage between those two registers.
//   When the receiver stalls, the result register holds its flag and the
//   input register holds the next pixel; req_ready drops only while both
//   are full, so nothing is lost or repeated.
//   Synchronous reset empties both registers and restores the limits to
//   45, 330, 15 percent and 25.
`default_nettype none

module hsv_skin_pixel_classifier (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire hsvskin_pkg::pixel_type    req_red,
   input  wire hsvskin_pkg::pixel_type    req_green,
   input  wire hsvskin_pkg::pixel_type    req_blue,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_skin_flag,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire hsvskin_pkg::csr_index_type csr_index,
   input  wire hsvskin_pkg::csr_data_type  csr_data
);

   import hsvskin_pkg::*;

`include "hsv_skin_pixel_classifier_assert.svh"

   // Limit registers.
   logic [HUE_WIDTH-1:0]   hue_lower_ff;
   logic [HUE_WIDTH-1:0]   hue_wrap_ff;
   logic [SAT_WIDTH-1:0]   sat_min_ff;
   logic [VALUE_WIDTH-1:0] value_min_ff;

   // Input stage and result stage.
   logic      in_valid_ff;
   logic      in_valid_in;
   pixel_type red_ff;
   pixel_type green_ff;
   pixel_type blue_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      skin_ff;
   logic      skin_in;
   logic      advance;
   logic      req_take;

   // Classify datapath signals.
   pixel_type                    max_val;
   pixel_type                    min_val;
   pixel_type                    diff;
   logic                         red_is_max;
   logic                         green_is_max;
   logic signed [PIXEL_WIDTH:0]  chan_delta;
   logic signed [HD_WIDTH-1:0]   delta_ext;
   logic signed [HD_WIDTH-1:0]   diff_ext;
   logic signed [HD_WIDTH-1:0]   sector_base;
   logic signed [HD_WIDTH-1:0]   hue_scaled;
   logic [PROD_WIDTH-1:0]        hue_scaled_u;
   logic [PROD_WIDTH-1:0]        lower_prod;
   logic [PROD_WIDTH-1:0]        wrap_prod;
   logic [SAT_PROD_WIDTH-1:0]    sat_lhs;
   logic [SAT_PROD_WIDTH-1:0]    sat_rhs;
   logic                         hue_ok;
   logic                         sat_ok;
   logic                         val_ok;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   // Handshake control for the two-register pipeline.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign rsp_valid     = out_valid_ff;
   assign rsp_skin_flag = skin_ff;

   // Largest channel with red, then green, winning ties; smallest channel.
   always_comb begin
      red_is_max   = (red_ff >= green_ff) && (red_ff >= blue_ff);
      green_is_max = !red_is_max && (green_ff >= blue_ff);
      if (red_is_max) begin
         max_val = red_ff;
      end else if (green_is_max) begin
         max_val = green_ff;
      end else begin
         max_val = blue_ff;
      end
      min_val = red_ff;
      if (green_ff < min_val) begin
         min_val = green_ff;
      end
      if (blue_ff < min_val) begin
         min_val = blue_ff;
      end
      diff = max_val - min_val;
   end

   // Hue times diff, as sector base plus sixty times the channel delta.
   always_comb begin
      if (red_is_max) begin
         chan_delta = $signed({1'b0, green_ff}) - $signed({1'b0, blue_ff});
      end else if (green_is_max) begin
         chan_delta = $signed({1'b0, blue_ff}) - $signed({1'b0, red_ff});
      end else begin
         chan_delta = $signed({1'b0, red_ff}) - $signed({1'b0, green_ff});
      end
      delta_ext = {{(HD_WIDTH-PIXEL_WIDTH-1){chan_delta[PIXEL_WIDTH]}}, chan_delta};
      diff_ext  = $signed({{(HD_WIDTH-PIXEL_WIDTH){1'b0}}, diff});
      if (red_is_max) begin
         sector_base = chan_delta[PIXEL_WIDTH] ? DEG_FULL_TURN * diff_ext : '0;
      end else if (green_is_max) begin
         sector_base = DEG_GREEN_BASE * diff_ext;
      end else begin
         sector_base = DEG_BLUE_BASE * diff_ext;
      end
      hue_scaled   = DEG_SECTOR * delta_ext + sector_base;
      hue_scaled_u = hue_scaled[PROD_WIDTH-1:0];
   end

   // Limit tests by cross-multiplication; all comparisons are strict.
   always_comb begin
      lower_prod = PROD_WIDTH'(hue_lower_ff) * PROD_WIDTH'(diff);
      wrap_prod  = PROD_WIDTH'(hue_wrap_ff) * PROD_WIDTH'(diff);
      sat_lhs    = SAT_PROD_WIDTH'(diff) * PERCENT_FULL;
      sat_rhs    = SAT_PROD_WIDTH'(sat_min_ff) * SAT_PROD_WIDTH'(max_val);
      hue_ok     = (hue_scaled_u < lower_prod) || (hue_scaled_u > wrap_prod);
      sat_ok     = sat_lhs > sat_rhs;
      val_ok     = max_val > value_min_ff;
      skin_in    = (diff != '0) && hue_ok && sat_ok && val_ok;
   end

   // Control state and limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hue_lower_ff <= HUE_LOWER_RESET;
         hue_wrap_ff  <= HUE_WRAP_RESET;
         sat_min_ff   <= SAT_MIN_RESET;
         value_min_ff <= VALUE_MIN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HUE_LOWER: hue_lower_ff <= csr_data[HUE_WIDTH-1:0];
               REG_HUE_WRAP:  hue_wrap_ff  <= csr_data[HUE_WIDTH-1:0];
               REG_SAT_MIN:   sat_min_ff   <= csr_data[SAT_WIDTH-1:0];
               REG_VALUE_MIN: value_min_ff <= csr_data[VALUE_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
      if (advance) begin
         skin_ff <= skin_in;
      end
   end

   // A classified pixel always lands in the result register.
   `HSVSKIN_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff,
      "classified pixel did not reach the result register")

   // A grey pixel is never flagged.
   `HSVSKIN_ASSERT_NEXT(a_grey_not_skin, clock, reset, advance && (diff == '0), !skin_ff,
      "grey pixel flagged as skin")

   // A dark pixel is never flagged.
   `HSVSKIN_ASSERT_NEXT(a_dark_not_skin, clock, reset,
      advance && (max_val <= value_min_ff), !skin_ff,
      "pixel at or below the value limit flagged as skin")

   // A pixel waiting in the input register is kept while the output stalls.
   `HSVSKIN_ASSERT_NEXT(a_input_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(red_ff) && $stable(green_ff) && $stable(blue_ff),
      "stalled pixel changed in the input register")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the HSV skin pixel classifier.
// Depends on hsvskin_pkg and the hsv_skin_pixel_classifier RTL, which includes the assertion header.
// Directed pixels, then random ones, over several limit settings, against a built-in predictor.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hsvskin_pkg::*;

   localparam int CYCLE_LIMIT = 600_000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_COUNT = 10;
   localparam int PIXELS_PER_PHASE = 200;
   localparam int MAX_PRINTED = 30;
   localparam int DIRECTED_COUNT = 20;

   // One row of the directed table: the pixel, and a typed-in flag where it is obvious.
   typedef struct packed {
      pixel_type red;
      pixel_type green;
      pixel_type blue;
      bit        typed;
      bit        flag;
   } pixel_row_type;

   localparam pixel_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0},  // black
      '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0},  // white
      '{8'd128, 8'd128, 8'd128, 1'b1, 1'b0},  // mid grey
      '{8'd255, 8'd0,   8'd0,   1'b1, 1'b1},  // pure red
      '{8'd0,   8'd255, 8'd0,   1'b1, 1'b0},  // pure green
      '{8'd0,   8'd0,   8'd255, 1'b1, 1'b0},  // pure blue
      '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0},  // red and blue tie, red wins, hue 300
      '{8'd255, 8'd255, 8'd0,   1'b1, 1'b0},  // red and green tie, hue 60
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0},  // green and blue tie
      '{8'd200, 8'd150, 8'd0,   1'b1, 1'b0},  // hue exactly on the lower limit
      '{8'd200, 8'd149, 8'd0,   1'b0, 1'b0},  // hue just below the lower limit
      '{8'd200, 8'd0,   8'd100, 1'b1, 1'b0},  // hue exactly on the wrap limit
      '{8'd200, 8'd0,   8'd99,  1'b0, 1'b0},  // hue just above the wrap limit
      '{8'd200, 8'd170, 8'd170, 1'b1, 1'b0},  // saturation exactly on its limit
      '{8'd200, 8'd171, 8'd171, 1'b0, 1'b0},  // saturation just under its limit
      '{8'd25,  8'd0,   8'd0,   1'b1, 1'b0},  // value exactly on its limit
      '{8'd26,  8'd0,   8'd0,   1'b1, 1'b1},  // value just above its limit
      '{8'd255, 8'd254, 8'd254, 1'b0, 1'b0},  // nearly grey bright red
      '{8'd1,   8'd0,   8'd0,   1'b0, 1'b0},  // darkest red
      '{8'd255, 8'd0,   8'd1,   1'b0, 1'b0}   // hue just short of a full turn
   };

   // Clock, reset and the block's inputs, all known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   pixel_type req_red = '0;
   pixel_type req_green = '0;
   pixel_type req_blue = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type csr_data = '0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_skin_flag;
   logic csr_ready;

   // Typed-in expectation that travels with the pixel currently offered.
   bit req_typed = 1'b0;
   bit req_typed_flag = 1'b0;

   // Shadow copy of the limit registers.
   logic [HUE_WIDTH-1:0]   lim_hue_lower = HUE_LOWER_RESET;
   logic [HUE_WIDTH-1:0]   lim_hue_wrap = HUE_WRAP_RESET;
   logic [SAT_WIDTH-1:0]   lim_sat_min = SAT_MIN_RESET;
   logic [VALUE_WIDTH-1:0] lim_value_min = VALUE_MIN_RESET;

   bit expected_flags [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int pixels_sent = 0;
   int flags_checked = 0;
   int skin_seen = 0;
   int settings_used = 1;
   bit quiet_sender = 1'b0;
   int ready_left = 0;

   hsv_skin_pixel_classifier uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_skin_flag(rsp_skin_flag),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d flags pending", cycle_count,
                  expected_flags.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Print one line per mismatch, up to a cap, and count them all.
   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Predict the skin flag of one pixel under the shadow limits.
   function automatic bit classify_pixel(input pixel_type r, input pixel_type g,
                                         input pixel_type b);
      int ri, gi, bi, top, bottom, d, hd;
      bit hue_hit, sat_hit, val_hit;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      top = ri;
      if (gi > top) top = gi;
      if (bi > top) top = bi;
      bottom = ri;
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      d = top - bottom;
      // A grey pixel has no hue and is never skin.
      if (d == 0) return 1'b0;
      // Hue scaled by d; ties on the maximum go to red, then green.
      if (top == ri) begin
         hd = 60 * (gi - bi);
         if (hd < 0) hd += 360 * d;
      end else if (top == gi) begin
         hd = 60 * (bi - ri) + 120 * d;
      end else begin
         hd = 60 * (ri - gi) + 240 * d;
      end
      hue_hit = (hd < int'(lim_hue_lower) * d) || (hd > int'(lim_hue_wrap) * d);
      sat_hit = (100 * d) > int'(lim_sat_min) * top;
      val_hit = top > int'(lim_value_min);
      return hue_hit && sat_hit && val_hit;
   endfunction

   // Mirror a register write into the shadow limits; unknown indexes change nothing.
   function automatic void apply_limit(input csr_index_type idx, input csr_data_type data);
      case (idx)
         REG_HUE_LOWER: lim_hue_lower = data[HUE_WIDTH-1:0];
         REG_HUE_WRAP:  lim_hue_wrap = data[HUE_WIDTH-1:0];
         REG_SAT_MIN:   lim_sat_min = data[SAT_WIDTH-1:0];
         REG_VALUE_MIN: lim_value_min = data[VALUE_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: runs of ready and stall of random length, some of them long.
   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 30);
      end else begin
         rsp_ready <= 1'b1;
         ready_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 5)
                                                   : $urandom_range(20, 80);
      end
   end

   // Monitor: check each result transaction, then record each accepted pixel.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_flags.size() == 0) begin
               report_mismatch("skin flag with no pixel pending", -1, rsp_skin_flag);
            end else begin
               if (rsp_skin_flag !== expected_flags[0])
                  report_mismatch("skin flag", expected_flags[0], rsp_skin_flag);
               void'(expected_flags.pop_front());
            end
            flags_checked++;
            if (rsp_skin_flag === 1'b1) skin_seen++;
         end
         if (req_valid && req_ready) begin
            if (req_typed) expected_flags.push_back(req_typed_flag);
            else expected_flags.push_back(classify_pixel(req_red, req_green, req_blue));
         end
      end
   end

   // Offer one pixel and hold it until the transaction completes; then maybe idle.
   task automatic send_pixel(input pixel_type r, input pixel_type g, input pixel_type b,
                             input bit typed, input bit flag);
      int gap;
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_typed <= typed;
      req_typed_flag <= flag;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every pixel in flight has its flag back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; valid stays high for a following write.
   task automatic csr_write(input csr_index_type idx, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_limit(idx, data);
   endtask

   // Write all four limits, with a write to an unused index in the middle.
   task automatic write_limits(input int hue_lower, input int hue_wrap,
                               input int sat_min, input int value_min);
      csr_write(REG_HUE_LOWER, csr_data_type'(hue_lower));
      csr_write(REG_HUE_WRAP, csr_data_type'(hue_wrap));
      csr_write(csr_index_type'($urandom_range(4, 255)), csr_data_type'($urandom));
      csr_write(REG_SAT_MIN, csr_data_type'(sat_min));
      csr_write(REG_VALUE_MIN, csr_data_type'(value_min));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Pick the limits of one phase: fixed settings first (extremes and reset values), then random ones.
   task automatic configure_phase(input int phase);
      case (phase)
         0: write_limits(0, 0, 0, 0);
         1: write_limits(511, 511, 127, 255);
         2: write_limits(360, 360, 100, 255);
         3: write_limits(45, 330, 15, 25);
         4: write_limits(400, 400, 0, 0);
         default: begin
            if (phase % 2 == 1)
               write_limits($urandom_range(0, 360), $urandom_range(0, 360),
                            $urandom_range(0, 100), $urandom_range(0, 255));
            else
               write_limits($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 511), $urandom_range(0, 511));
         end
      endcase
   endtask

   // Random pixel, biased toward red-dominant colors, greys, tied maxima and channels at 0 or 255.
   task automatic random_pixel(output pixel_type r, output pixel_type g, output pixel_type b);
      int mode, peak, other;
      mode = $urandom_range(0, 9);
      r = pixel_type'($urandom);
      g = pixel_type'($urandom);
      b = pixel_type'($urandom);
      if (mode >= 4 && mode <= 6) begin
         g = pixel_type'($urandom_range(0, r));
         b = pixel_type'($urandom_range(0, r));
      end else if (mode == 7) begin
         g = r;
         b = r;
      end else if (mode == 8) begin
         peak = $urandom_range(1, 255);
         other = $urandom_range(0, peak);
         case ($urandom_range(0, 2))
            0: begin
               r = pixel_type'(peak);
               g = pixel_type'(peak);
               b = pixel_type'(other);
            end
            1: begin
               r = pixel_type'(peak);
               g = pixel_type'(other);
               b = pixel_type'(peak);
            end
            default: begin
               r = pixel_type'(other);
               g = pixel_type'(peak);
               b = pixel_type'(peak);
            end
         endcase
      end else if (mode == 9) begin
         r = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : r);
         g = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : g);
         b = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : b);
      end
   endtask

   // Main sequence: reset, directed table under reset limits, then random phases.
   initial begin
      pixel_type r, g, b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_pixel(DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].blue,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].flag);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         configure_phase(phase);
         quiet_sender = (phase % 4 == 2);
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b, 1'b0, 1'b0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_flags.size() != 0)
         report_mismatch("skin flags never returned", 0, expected_flags.size());

      $display("Sent %0d pixels (%0d directed) under %0d limit settings.", pixels_sent,
               DIRECTED_COUNT, settings_used);
      $display("Checked %0d skin flags, %0d of them set; %0d mismatches.", flags_checked,
               skin_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
